### rtl/tss_pkg.sv
// shared types and constants of the square-wave tone sequencer
// used by tss_div and tone_sequencer_square_wave, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

	// field widths
	localparam int FUNC_W   = 3;
	localparam int TIME_W   = 32;
	localparam int IDX_W    = 4;
	localparam int FREQ_W   = 16;
	localparam int DUR_W    = 16;
	localparam int CNT_W    = 5;
	localparam int DAC_W    = 10;
	localparam int SWING_W  = 9;
	localparam int HALF_W   = 19;
	localparam int ENTRY_W  = FREQ_W + DUR_W;
	localparam int CFG_IDX_W = 1;

	// default table depths
	localparam int BG_DEPTH_DEF  = 16;
	localparam int CUE_DEPTH_DEF = 16;

	// function codes
	localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE_BG  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_WRITE_CUE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_START_BG  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_START_CUE = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DAC_MID   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DAC_SWING = 1'b1;

	// register reset values
	localparam logic [DAC_W-1:0]   DAC_MID_RESET   = 10'd512;
	localparam logic [SWING_W-1:0] DAC_SWING_RESET = 9'd150;

	// timing constants
	localparam int MS_W = 10;
	localparam logic [MS_W-1:0] US_PER_MS = 10'd1000;
	localparam int PROD_W = DUR_W + MS_W;

	// half-period divider: 1000000 / (2 * freq)
	localparam int DVD_W     = 20;
	localparam int DVS_W     = FREQ_W + 1;
	localparam int REM_W     = DVS_W + 1;
	localparam int DIV_CNT_W = 5;
	localparam logic [DVD_W-1:0] US_PER_S = 20'd1000000;

	typedef struct packed {
		logic             start;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

### rtl/tss_div.sv
// restoring divider for the tone half-period, one quotient bit per cycle
// depends on tss_pkg
`timescale 1ns / 1ps
`default_nettype none

module tss_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tss_pkg::div_req_t req,
	output tss_pkg::div_rsp_t      rsp
);
	import tss_pkg::*;

	logic [REM_W-1:0]     rem_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [DVD_W-1:0]     quo_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [REM_W-1:0]     shifted;
	logic                 fits;

	assign shifted = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			// done pulses for one cycle after the last quotient bit
			done_q <= busy_q && !req.start && (cnt_q == DIV_CNT_W'(DVD_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				dvd_q  <= US_PER_S;
				quo_q  <= '0;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= fits ? shifted - {1'b0, dvs_q} : shifted;
				quo_q <= {quo_q[DVD_W-2:0], fits};
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

### rtl/tone_sequencer_square_wave.sv
// square-wave tone sequencer: background and cue tone tables, dac level output
// depends on tss_pkg and tss_div
// a tick is decided in the exec state, and a toggle goes via emit to the output register
// a start or a step change runs read, load and the 20-step half-period divider
// one transaction is worked on at a time; a pending result waits in the output register
// reset clears all control state and loads the dac registers with 512 and 150
// table contents are not reset and hold garbage until written
`timescale 1ns / 1ps
`default_nettype none

module tone_sequencer_square_wave #(
	parameter int BACKGROUND_DEPTH = tss_pkg::BG_DEPTH_DEF,
	parameter int CUE_DEPTH        = tss_pkg::CUE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// register write port
	input  wire logic                           cfg_we,
	input  wire logic [tss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tss_pkg::DAC_W-1:0]      cfg_data,
	// input transactions
	input  wire logic                           item_valid,
	output logic                                item_stall,
	input  wire logic [tss_pkg::FUNC_W-1:0]     func,
	input  wire logic [tss_pkg::TIME_W-1:0]     now_us,
	input  wire logic [tss_pkg::IDX_W-1:0]      entry_index,
	input  wire logic [tss_pkg::FREQ_W-1:0]     freq_hz,
	input  wire logic [tss_pkg::DUR_W-1:0]      duration_ms,
	input  wire logic [tss_pkg::CNT_W-1:0]      entry_count,
	// result transactions
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output logic [tss_pkg::DAC_W-1:0]           dac_level
);
	import tss_pkg::*;

	localparam int BG_AW  = (BACKGROUND_DEPTH > 1) ? $clog2(BACKGROUND_DEPTH) : 1;
	localparam int CUE_AW = (CUE_DEPTH > 1) ? $clog2(CUE_DEPTH) : 1;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a transaction
	localparam logic [2:0] ST_EXEC = 3'd1;  // decide what the transaction does
	localparam logic [2:0] ST_READ = 3'd2;  // table read in flight
	localparam logic [2:0] ST_LOAD = 3'd3;  // entry available, launch divider
	localparam logic [2:0] ST_DIV  = 3'd4;  // wait for the half-period
	localparam logic [2:0] ST_EMIT = 3'd5;  // hand the level to the output register

	logic [2:0] state_q;

	// dac registers
	logic [DAC_W-1:0]   mid_q;
	logic [SWING_W-1:0] swing_q;

	// captured transaction
	logic [FUNC_W-1:0] func_q;
	logic [TIME_W-1:0] now_q;
	logic [CNT_W-1:0]  cnt_q;

	// playback state
	logic [CNT_W-1:0]  bg_count_q;
	logic [CNT_W-1:0]  cue_count_q;
	logic [CNT_W-1:0]  bg_pos_q;
	logic [CNT_W-1:0]  cue_pos_q;
	logic              cue_active_q;
	logic [HALF_W-1:0] half_q;
	logic [TIME_W-1:0] step_end_q;
	logic [TIME_W-1:0] last_toggle_q;
	logic              level_high_q;

	// table read path
	logic              rd_cue_q;
	logic [BG_AW-1:0]  bg_addr_q;
	logic [CUE_AW-1:0] cue_addr_q;
	logic [ENTRY_W-1:0] bg_rd_q;
	logic [ENTRY_W-1:0] cue_rd_q;
	logic [ENTRY_W-1:0] bg_mem_q  [BACKGROUND_DEPTH];
	logic [ENTRY_W-1:0] cue_mem_q [CUE_DEPTH];

	// step start
	logic [PROD_W-1:0] prod_q;
	logic              rest_q;
	logic [DAC_W-1:0]  pend_q;

	// output register
	logic             out_valid_q;
	logic [DAC_W-1:0] out_level_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic               accept;
	logic               wr_bg;
	logic               wr_cue;
	logic [BG_AW-1:0]   bg_waddr;
	logic [CUE_AW-1:0]  cue_waddr;
	logic [CNT_W-1:0]   bg_clamp;
	logic [CNT_W-1:0]   cue_clamp;
	logic [TIME_W-1:0]  since_end;
	logic [TIME_W-1:0]  since_toggle;
	logic               step_done;
	logic               half_elapsed;
	logic [CNT_W-1:0]   bg_pos_inc;
	logic [CNT_W-1:0]   bg_pos_nxt;
	logic [CNT_W-1:0]   cue_pos_inc;
	logic [DAC_W:0]     hi_sum;
	logic [DAC_W-1:0]   code_hi;
	logic [DAC_W-1:0]   code_lo;
	logic [ENTRY_W-1:0] entry;
	logic               out_free;

	// only one transaction is worked on at a time
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	// table writes go straight in at the accepting edge; out-of-range indexes drop
	assign wr_bg     = accept && (func == FUNC_WRITE_BG) && (32'(entry_index) < BACKGROUND_DEPTH);
	assign wr_cue    = accept && (func == FUNC_WRITE_CUE) && (32'(entry_index) < CUE_DEPTH);
	assign bg_waddr  = BG_AW'(entry_index);
	assign cue_waddr = CUE_AW'(entry_index);

	// entry counts saturate at the table depth
	assign bg_clamp  = (32'(cnt_q) > BACKGROUND_DEPTH) ? CNT_W'(BACKGROUND_DEPTH) : cnt_q;
	assign cue_clamp = (32'(cnt_q) > CUE_DEPTH) ? CNT_W'(CUE_DEPTH) : cnt_q;

	// wrapping time compares: the step is over once now - end is not negative
	assign since_end    = now_q - step_end_q;
	assign since_toggle = now_q - last_toggle_q;
	assign step_done    = !since_end[TIME_W-1];
	assign half_elapsed = since_toggle >= TIME_W'(half_q);

	// background loops; position stays below the count, so a compare replaces the modulo
	assign bg_pos_inc  = bg_pos_q + 1'b1;
	assign bg_pos_nxt  = (bg_pos_inc == bg_count_q) ? '0 : bg_pos_inc;
	assign cue_pos_inc = cue_pos_q + 1'b1;

	// saturated dac codes for the high and low halves
	assign hi_sum  = {1'b0, mid_q} + (DAC_W + 1)'(swing_q);
	assign code_hi = hi_sum[DAC_W] ? {DAC_W{1'b1}} : hi_sum[DAC_W-1:0];
	assign code_lo = (DAC_W'(swing_q) > mid_q) ? '0 : mid_q - DAC_W'(swing_q);

	assign entry = rd_cue_q ? cue_rd_q : bg_rd_q;

	assign div_req.start   = (state_q == ST_LOAD);
	assign div_req.divisor = {entry[FREQ_W-1:0], 1'b0};

	assign out_free = !out_valid_q || !result_stall;

	tss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// tone tables: one write port from the input side, one registered read port each;
	// a write and a read of the same entry never overlap since transactions run one at a time
	always_ff @(posedge clk) begin
		if (wr_bg) begin
			bg_mem_q[bg_waddr] <= {duration_ms, freq_hz};
		end
		if (wr_cue) begin
			cue_mem_q[cue_waddr] <= {duration_ms, freq_hz};
		end
		bg_rd_q  <= bg_mem_q[bg_addr_q];
		cue_rd_q <= cue_mem_q[cue_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mid_q         <= DAC_MID_RESET;
			swing_q       <= DAC_SWING_RESET;
			func_q        <= FUNC_TICK;
			now_q         <= '0;
			cnt_q         <= '0;
			bg_count_q    <= '0;
			cue_count_q   <= '0;
			bg_pos_q      <= '0;
			cue_pos_q     <= '0;
			cue_active_q  <= 1'b0;
			half_q        <= '0;
			step_end_q    <= '0;
			last_toggle_q <= '0;
			level_high_q  <= 1'b0;
			rd_cue_q      <= 1'b0;
			bg_addr_q     <= '0;
			cue_addr_q    <= '0;
			prod_q        <= '0;
			rest_q        <= 1'b0;
			pend_q        <= '0;
			out_valid_q   <= 1'b0;
			out_level_q   <= '0;
		end else begin
			// register writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DAC_MID:   mid_q   <= cfg_data;
					REG_DAC_SWING: swing_q <= cfg_data[SWING_W-1:0];
					default: ;
				endcase
			end

			// output register: load a new level from the emit state, else drain
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
				out_level_q <= pend_q;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						func_q <= func;
						now_q  <= now_us;
						cnt_q  <= entry_count;
						if (func == FUNC_TICK || func == FUNC_START_BG
							|| func == FUNC_START_CUE) begin
							state_q <= ST_EXEC;
						end
					end
				end

				ST_EXEC: begin
					unique case (func_q)
						FUNC_START_BG: begin
							bg_count_q <= bg_clamp;
							bg_pos_q   <= '0;
							// while a cue plays, only count and position are taken
							if (!cue_active_q && bg_clamp != '0) begin
								rd_cue_q  <= 1'b0;
								bg_addr_q <= '0;
								state_q   <= ST_READ;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						FUNC_START_CUE: begin
							cue_count_q  <= cue_clamp;
							cue_pos_q    <= '0;
							cue_active_q <= 1'b1;
							// an empty cue stays active until the old step ends
							if (cue_clamp != '0) begin
								rd_cue_q   <= 1'b1;
								cue_addr_q <= '0;
								state_q    <= ST_READ;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						FUNC_TICK: begin
							if (!cue_active_q && bg_count_q == '0) begin
								state_q <= ST_IDLE;
							end else if (step_done) begin
								if (cue_active_q) begin
									if (cue_pos_inc < cue_count_q) begin
										cue_pos_q  <= cue_pos_inc;
										rd_cue_q   <= 1'b1;
										cue_addr_q <= CUE_AW'(cue_pos_inc);
										state_q    <= ST_READ;
									end else begin
										// cue over: resume background or fall silent
										cue_active_q <= 1'b0;
										cue_pos_q    <= '0;
										if (bg_count_q != '0) begin
											rd_cue_q  <= 1'b0;
											bg_addr_q <= BG_AW'(bg_pos_q);
											state_q   <= ST_READ;
										end else begin
											pend_q  <= mid_q;
											state_q <= ST_EMIT;
										end
									end
								end else begin
									bg_pos_q  <= bg_pos_nxt;
									rd_cue_q  <= 1'b0;
									bg_addr_q <= BG_AW'(bg_pos_nxt);
									state_q   <= ST_READ;
								end
							end else if (half_q != '0 && half_elapsed) begin
								last_toggle_q <= now_q;
								level_high_q  <= !level_high_q;
								pend_q        <= level_high_q ? code_lo : code_hi;
								state_q       <= ST_EMIT;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end

				ST_READ: begin
					state_q <= ST_LOAD;
				end

				ST_LOAD: begin
					// divider launches here; the step end waits for the product register
					prod_q        <= entry[ENTRY_W-1:FREQ_W] * US_PER_MS;
					rest_q        <= (entry[FREQ_W-1:0] == '0);
					last_toggle_q <= now_q;
					level_high_q  <= 1'b0;
					state_q       <= ST_DIV;
				end

				ST_DIV: begin
					if (div_rsp.done) begin
						half_q     <= rest_q ? '0 : HALF_W'(div_rsp.quotient);
						step_end_q <= now_q + TIME_W'(prod_q);
						state_q    <= ST_IDLE;
					end
				end

				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign dac_level    = out_level_q;

	// the half-period is 1000000 / (2 * freq), never above 500000 us
	a_half_range: assert property (@(posedge clk) disable iff (!arst_n)
		half_q <= HALF_W'(500000))
		else $error("half-period out of range");

	// an active cue never runs past its count
	a_cue_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cue_active_q |-> (cue_pos_q <= cue_count_q))
		else $error("cue position beyond count");

	// a looping background position stays inside the count
	a_bg_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(bg_count_q != '0) |-> (bg_pos_q < bg_count_q))
		else $error("background position beyond count");

	// the divider only finishes while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider done outside wait state");

	// a new result is loaded only from the emit state
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == ST_EMIT))
		else $error("result produced outside emit state");

endmodule

`default_nettype wire
